// File: design/ewu_pkg.sv
// Shared constants, types and helpers for the averaged parameter update engine.
`timescale 1ns / 1ps
`default_nettype none

package ewu_pkg;

    // Store geometry. The store depth is a power of two so the index wraps by truncation.
    localparam int STORE_DEPTH = 4096;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths of the transaction ports and configuration registers.
    localparam int IDX_W   = 12;
    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 17;
    localparam int RATE_W  = 16;
    localparam int CFG_W   = 17;
    localparam int FRAC_W  = 16;

    // Internal arithmetic widths.
    localparam int RG_W    = RATE_W + DATA_W;
    localparam int R_W     = RG_W + 1 - FRAC_W;
    localparam int STEP_W  = R_W + 1;
    localparam int TERM_W  = GAIN_W + 1 + STEP_W;
    localparam int PROD_W  = VALUE_WIDTH + GAIN_W + 1;
    localparam int SUM_W   = ((PROD_W > TERM_W) ? PROD_W : TERM_W) + 1;
    localparam int AVG_W   = SUM_W - FRAC_W;

    localparam int ROUND_HALF = 32768;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 17'h10000;
    localparam logic [GAIN_W-1:0] THETA_RESET = 17'd58982;
    localparam logic [RATE_W-1:0] RATE_RESET  = 16'd655;

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    typedef enum logic {
        REG_THETA_GAIN    = 1'b0,
        REG_LEARNING_RATE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] theta;
        logic [RATE_W-1:0] rate;
    } gain_cfg_t;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         idx;
        logic                     first;
        logic signed [TERM_W-1:0] term;
    } blend_item_t;

    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
    } ram_rd_t;

    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
        logic [VALUE_WIDTH-1:0] data;
    } ram_wr_t;

    // Parameter index to store address; wraps modulo the store depth.
    function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

// File: design/ewu_avg_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ewu_avg_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/ewu_step_pipe.sv
// Front pipeline: rate product, rounded descent step, and the weighted step term.
`timescale 1ns / 1ps
`default_nettype none

module ewu_step_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ewu_pkg::IDX_W-1:0]           param_index,
    input  logic signed [ewu_pkg::DATA_W-1:0]   param_value,
    input  logic signed [ewu_pkg::DATA_W-1:0]   gradient,
    input  logic                                first_pass,
    input  ewu_pkg::gain_cfg_t                  gains,
    input  logic                                s3_take,
    output ewu_pkg::blend_item_t                s3_item,
    output ewu_pkg::ram_rd_t                    rd_req
);

    import ewu_pkg::*;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic                     s1_first_reg, s2_first_reg, s3_first_reg;
    logic signed [DATA_W-1:0] s1_value_reg;
    logic signed [RG_W-1:0]   s1_rg_reg;
    logic signed [STEP_W-1:0] s2_step_reg;
    logic signed [TERM_W-1:0] s3_term_reg;

    logic                     accept, s1_move, s2_move, s1_ready, s2_ready, s3_ready;
    logic signed [RG_W-1:0]   rate_ext, grad_ext, rg_next;
    logic signed [RG_W:0]     rg_sum;
    logic signed [R_W-1:0]    r_val;
    logic signed [STEP_W-1:0] step_next;
    logic [GAIN_W-1:0]        one_minus;
    logic signed [TERM_W-1:0] gain_ext, step_ext, term_next;

    // Each stage advances when the slot ahead of it is empty or emptying.
    assign s3_ready = !s3_valid_reg || s3_take;
    assign s2_move  = s2_valid_reg && s3_ready;
    assign s2_ready = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s1_move;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;

    assign rate_ext = {{(RG_W - RATE_W){1'b0}}, gains.rate};
    assign grad_ext = {{(RG_W - DATA_W){gradient[DATA_W-1]}}, gradient};
    assign rg_next  = rate_ext * grad_ext;

    // Round half up, then drop the gain fraction.
    assign rg_sum    = (RG_W + 1)'(s1_rg_reg) + (RG_W + 1)'(ROUND_HALF);
    assign r_val     = rg_sum[RG_W:FRAC_W];
    assign step_next = STEP_W'(s1_value_reg) - STEP_W'(r_val);

    assign one_minus = GAIN_ONE - gains.theta;
    assign gain_ext  = TERM_W'($signed({1'b0, one_minus}));
    assign step_ext  = TERM_W'(s2_step_reg);
    assign term_next = gain_ext * step_ext + TERM_W'(ROUND_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_move;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= param_index;
            s1_value_reg <= param_value;
            s1_first_reg <= first_pass;
            s1_rg_reg    <= rg_next;
        end
        if (s1_move)
        begin
            s2_idx_reg   <= s1_idx_reg;
            s2_first_reg <= s1_first_reg;
            s2_step_reg  <= step_next;
        end
        if (s2_move)
        begin
            s3_idx_reg   <= s2_idx_reg;
            s3_first_reg <= s2_first_reg;
            s3_term_reg  <= term_next;
        end
    end

    // The stored average is fetched as the item enters the blend stage.
    assign rd_req.en   = s2_move;
    assign rd_req.addr = store_addr(s2_idx_reg);

    assign s3_item.valid = s3_valid_reg;
    assign s3_item.idx   = s3_idx_reg;
    assign s3_item.first = s3_first_reg;
    assign s3_item.term  = s3_term_reg;

endmodule

`default_nettype wire

// File: design/ewu_blend.sv
// Blend stage: averages with the stored value, saturates, writes back and holds the result.
`timescale 1ns / 1ps
`default_nettype none

module ewu_blend (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ewu_pkg::blend_item_t                  s3_item,
    input  ewu_pkg::gain_cfg_t                    gains,
    input  logic [ewu_pkg::VALUE_WIDTH-1:0]       rd_data,
    output logic                                  s3_take,
    output ewu_pkg::ram_wr_t                      wr_req,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ewu_pkg::IDX_W-1:0]             result_index,
    output logic signed [ewu_pkg::DATA_W-1:0]     new_value,
    output logic                                  saturated
);

    import ewu_pkg::*;

    logic                          out_valid_reg, last_valid_reg;
    logic [IDX_W-1:0]              result_index_reg;
    logic signed [DATA_W-1:0]      new_value_reg;
    logic                          saturated_reg;
    logic [ADDR_W-1:0]             last_addr_reg;
    logic signed [VALUE_WIDTH-1:0] last_avg_reg;

    logic [ADDR_W-1:0]             addr3;
    logic                          fwd_hit, sat_next;
    logic signed [VALUE_WIDTH-1:0] old_val, avg_sat;
    logic signed [SUM_W-1:0]       theta_ext, old_ext, term_ext, prod, sum;
    logic signed [AVG_W-1:0]       avg_full, max_ext, min_ext;

    assign s3_take = s3_item.valid && (!out_valid_reg || !out_stall);
    assign addr3   = store_addr(s3_item.idx);

    // The write of the previous transaction lands in the same cycle as this read,
    // so the latest written average for the address is taken from the bypass register.
    assign fwd_hit = last_valid_reg && (last_addr_reg == addr3);

    always_comb
    begin
        if (s3_item.first)
        begin
            old_val = '0;
        end
        else if (fwd_hit)
        begin
            old_val = last_avg_reg;
        end
        else
        begin
            old_val = $signed(rd_data);
        end
    end

    assign theta_ext = SUM_W'($signed({1'b0, gains.theta}));
    assign old_ext   = SUM_W'(old_val);
    assign term_ext  = SUM_W'($signed(s3_item.term));
    assign prod      = theta_ext * old_ext;
    assign sum       = prod + term_ext;
    assign avg_full  = sum[SUM_W-1:FRAC_W];
    assign max_ext   = AVG_W'(VALUE_MAX);
    assign min_ext   = AVG_W'(VALUE_MIN);

    always_comb
    begin
        if (avg_full > max_ext)
        begin
            avg_sat  = VALUE_MAX;
            sat_next = 1'b1;
        end
        else if (avg_full < min_ext)
        begin
            avg_sat  = VALUE_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            avg_sat  = VALUE_WIDTH'(avg_full);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s3_take || (out_valid_reg && out_stall);
            if (s3_take)
            begin
                last_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_take)
        begin
            result_index_reg <= s3_item.idx;
            new_value_reg    <= DATA_W'(avg_sat);
            saturated_reg    <= sat_next;
            last_addr_reg    <= addr3;
            last_avg_reg     <= avg_sat;
        end
    end

    assign wr_req.en   = s3_take;
    assign wr_req.addr = addr3;
    assign wr_req.data = avg_sat;

    assign out_valid    = out_valid_reg;
    assign result_index = result_index_reg;
    assign new_value    = new_value_reg;
    assign saturated    = saturated_reg;

endmodule

`default_nettype wire

// File: design/ema_weight_update_engine.sv
// Top level of the averaged parameter update engine.
// Each accepted transaction is registered in stages s1, s2 and s3, then in the output register.
// Throughput: one transaction per cycle unless a result stalls; the blend stage (multiply, add,
// saturate, write back) closes the per-index loop via a bypass, so repeats run back to back.
// Reset clears all valid flags and loads the gains with their reset values; the average store
// has no reset and an entry holds a defined value once a first-pass transaction has written it.
`timescale 1ns / 1ps
`default_nettype none

module ema_weight_update_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [0:0]                         cfg_index,
    input  logic [ewu_pkg::CFG_W-1:0]          cfg_data,
    // Input transaction channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ewu_pkg::IDX_W-1:0]          param_index,
    input  logic signed [ewu_pkg::DATA_W-1:0]  param_value,
    input  logic signed [ewu_pkg::DATA_W-1:0]  gradient,
    input  logic                               first_pass,
    // Result transaction channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ewu_pkg::IDX_W-1:0]          result_index,
    output logic signed [ewu_pkg::DATA_W-1:0]  new_value,
    output logic                               saturated
);

    import ewu_pkg::*;

    // The averaging factor is clamped to one when it is written, so the datapath
    // never sees a theta above 1.0 and the complementary gain never goes negative.
    logic [GAIN_W-1:0] theta_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [GAIN_W-1:0] theta_wr;

    gain_cfg_t   gains;
    blend_item_t s3_item;
    logic        s3_take;
    ram_rd_t     ram_rd;
    ram_wr_t     ram_wr;
    logic [VALUE_WIDTH-1:0] rd_data;

    assign theta_wr = (cfg_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : cfg_data[GAIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_reg <= THETA_RESET;
            rate_reg  <= RATE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THETA_GAIN:    theta_reg <= theta_wr;
                REG_LEARNING_RATE: rate_reg  <= cfg_data[RATE_W-1:0];
                default:           theta_reg <= theta_reg;
            endcase
        end
    end

    assign gains.theta = theta_reg;
    assign gains.rate  = rate_reg;

    // Three front stages form the descent step and its weighted share of the average.
    ewu_step_pipe u_step_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .param_index (param_index),
        .param_value (param_value),
        .gradient    (gradient),
        .first_pass  (first_pass),
        .gains       (gains),
        .s3_take     (s3_take),
        .s3_item     (s3_item),
        .rd_req      (ram_rd)
    );

    // One running average per parameter; read as an item enters the blend stage and
    // written as it leaves, one read and one write per cycle.
    ewu_avg_ram #(
        .DEPTH  (STORE_DEPTH),
        .WIDTH  (VALUE_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_avg_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.en),
        .rd_addr (ram_rd.addr),
        .rd_data (rd_data)
    );

    // The blend stage owns the output register, so a waiting result does not block
    // the front stages from filling.
    ewu_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .s3_item      (s3_item),
        .gains        (gains),
        .rd_data      (rd_data),
        .s3_take      (s3_take),
        .wr_req       (ram_wr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_index (result_index),
        .new_value    (new_value),
        .saturated    (saturated)
    );

`ifndef SYNTHESIS
    // The input side can only be held off when every stage is full behind a stalled result.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register was free");

    // Every write back of an average produces a result in the next cycle.
    a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr.en |=> out_valid)
        else $error("average written back without a result");

    // A clipped result sits exactly at one end of the value range.
    a_saturated_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            ((new_value == DATA_W'(VALUE_MAX)) || (new_value == DATA_W'(VALUE_MIN))))
        else $error("saturated result is not at a range bound");
`endif

endmodule

`default_nettype wire
